[rtl/core/dfw_pkg.sv]
package dfw_pkg;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int WIDTH_REG_W = 12;

	// (far_depth - depth) * view_offset, then * disp_scale
	localparam int MUL1_W = 14;
	localparam int PROD_W = 31;
	localparam int DISP_W = PROD_W - 8;

	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_VIEW_OFFSET = 2'd0,
		REG_DISP_SCALE  = 2'd1,
		REG_FAR_DEPTH   = 2'd2,
		REG_IMAGE_WIDTH = 2'd3
	} dfw_reg_t;

	typedef struct packed {
		logic signed [4:0]        view_offset;
		logic [15:0]              disp_scale;
		logic [7:0]               far_depth;
		logic [WIDTH_REG_W-1:0]   image_width;
	} dfw_cfg_t;

	localparam dfw_cfg_t CFG_RESET = '{
		view_offset:     5'sd0,
		disp_scale:      16'd256,
		far_depth:       8'd255,
		image_width:     12'd2048
	};

	// per-pixel attributes handed from the front to the back
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] depth;
		logic       lt_max;  // depth below the far depth: wins against a hole
		logic       warp;    // pixel has nonzero depth and lands inside the row
		logic       bank;    // bank written by this row
		logic       last;
	} dfw_attr_t;

	// one row store entry
	typedef struct packed {
		logic       hole;
		logic [7:0] depth;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} dfw_entry_t;

	localparam dfw_entry_t ENTRY_HOLE = '{hole: 1'b1, default: '0};

endpackage

[rtl/core/dfw_queue.sv]
module dfw_queue
	import dfw_pkg::*;
#(
	parameter int DW    = 8,
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [DW-1:0] in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [DW-1:0] out_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [DW-1:0]   buf_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0] cnt_q;
	logic            push, pop;

	assign in_ready  = (cnt_q != CNTW'(DEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_data  = buf_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNTW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNTW'(1);
			end
		end
	end

endmodule

[rtl/core/dfw_front.sv]
module dfw_front
	import dfw_pkg::*;
#(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dfw_cfg_t                     cfg,
	input  logic                         hold,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [7:0]                   depth_value,
	input  logic [7:0]                   src_red,
	input  logic [7:0]                   src_green,
	input  logic [7:0]                   src_blue,
	output logic                         item_valid,
	input  logic                         item_ready,
	output dfw_attr_t                    item_attr,
	output logic [$clog2(MAX_WIDTH)-1:0] item_x,
	output logic [$clog2(MAX_WIDTH)-1:0] item_t
);

	localparam int AW   = $clog2(MAX_WIDTH);
	localparam int WW   = $clog2(MAX_WIDTH + 1);
	localparam int CMPW = (WW > WIDTH_REG_W) ? WW : WIDTH_REG_W;
	localparam int NXW  = (AW + 2 > DISP_W + 1) ? AW + 2 : DISP_W + 1;

	logic [AW-1:0]   column_q;
	logic            bank_q;

	logic [CMPW-1:0] iw;
	logic [WW-1:0]   w_use;
	logic [AW-1:0]   x_cur;
	logic            last_cur;
	logic            accept;
	logic            rdy1, rdy2, rdy3;

	logic signed [8:0]        diff;
	logic signed [MUL1_W-1:0] mul1;

	logic                     vld_s1, vld_s2, vld_s3;
	dfw_attr_t                attr_s1, attr_s2, attr_s3;
	logic [AW-1:0]            x_s1, x_s2, x_s3;
	logic signed [MUL1_W-1:0] mul1_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [DISP_W-1:0] disp_s3;

	logic signed [PROD_W-1:0] bias, rnd;
	logic signed [NXW-1:0]    nx;
	logic                     in_range;

	// width in use, clamped to 1..MAX_WIDTH
	always_comb begin
		iw = CMPW'(cfg.image_width);
		if (iw == '0) begin
			w_use = WW'(1);
		end else if (iw > CMPW'(MAX_WIDTH)) begin
			w_use = WW'(MAX_WIDTH);
		end else begin
			w_use = WW'(iw);
		end
	end

	assign x_cur    = (WW'(column_q) >= w_use) ? AW'(w_use - WW'(1)) : column_q;
	assign last_cur = ((WW + 1)'(x_cur) + (WW + 1)'(1)) >= (WW + 1)'(w_use);

	assign rdy3     = !vld_s3 || item_ready;
	assign rdy2     = !vld_s2 || rdy3;
	assign rdy1     = !vld_s1 || rdy2;
	assign in_ready = rdy1 && !hold;
	assign accept   = in_valid && in_ready;

	assign diff = $signed({1'b0, cfg.far_depth}) - $signed({1'b0, depth_value});
	assign mul1 = MUL1_W'(diff) * MUL1_W'($signed(cfg.view_offset));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			bank_q   <= 1'b0;
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			vld_s3   <= 1'b0;
		end else begin
			if (accept) begin
				column_q <= last_cur ? '0 : x_cur + AW'(1);
				if (last_cur) begin
					bank_q <= !bank_q;
				end
			end
			if (rdy1) begin
				vld_s1 <= accept;
			end
			if (rdy2) begin
				vld_s2 <= vld_s1;
			end
			if (rdy3) begin
				vld_s3 <= vld_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			attr_s1.red    <= src_red;
			attr_s1.green  <= src_green;
			attr_s1.blue   <= src_blue;
			attr_s1.depth  <= depth_value;
			attr_s1.lt_max <= depth_value < cfg.far_depth;
			attr_s1.warp   <= depth_value != 8'd0;
			attr_s1.bank   <= bank_q;
			attr_s1.last   <= last_cur;
			x_s1           <= x_cur;
			mul1_s1        <= mul1;
		end
		if (rdy2 && vld_s1) begin
			attr_s2 <= attr_s1;
			x_s2    <= x_s1;
			prod_s2 <= PROD_W'(mul1_s1) * PROD_W'($signed({1'b0, cfg.disp_scale}));
		end
		if (rdy3 && vld_s2) begin
			attr_s3 <= attr_s2;
			x_s3    <= x_s2;
			disp_s3 <= rnd[PROD_W-1:8];
		end
	end

	// divide by 256 rounding toward zero
	assign bias = {{(PROD_W - 8){1'b0}}, {8{prod_s2[PROD_W-1]}}};
	assign rnd  = prod_s2 + bias;

	assign nx       = NXW'(signed'({1'b0, x_s3})) - NXW'(disp_s3);
	assign in_range = !nx[NXW-1] && (unsigned'(nx) < NXW'(w_use));

	always_comb begin
		item_attr      = attr_s3;
		item_attr.warp = attr_s3.warp && in_range;
	end

	assign item_valid = vld_s3;
	assign item_x     = x_s3;
	assign item_t     = item_attr.warp ? nx[AW-1:0] : '0;

endmodule

[rtl/core/dfw_back.sv]
module dfw_back
	import dfw_pkg::*;
#(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	output logic                         q_ready,
	input  dfw_attr_t                    q_attr,
	input  logic [$clog2(MAX_WIDTH)-1:0] q_x,
	input  logic [$clog2(MAX_WIDTH)-1:0] q_t,
	output logic                         init_busy,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [7:0]                   out_red,
	output logic [7:0]                   out_green,
	output logic [7:0]                   out_blue,
	output logic                         hole,
	output logic                         last_in_row
);

	localparam int AW = $clog2(MAX_WIDTH);

	logic          init_busy_q;
	logic [AW-1:0] clr_cnt_q;

	logic          issue, b_adv, b_free;
	logic          vld_s1;
	dfw_attr_t     attr_s1;
	logic [AW-1:0] x_s1, t_s1;

	dfw_entry_t    rdf [2];
	dfw_entry_t    cur_e, prev_e;
	logic          win;

	logic          out_valid_q;
	logic [7:0]    red_q, green_q, blue_q;
	logic          hole_q, last_q;

	assign b_adv   = vld_s1 && (!out_valid_q || out_ready);
	assign b_free  = !vld_s1 || b_adv;
	assign q_ready = b_free && !init_busy_q;
	assign issue   = q_valid && q_ready;

	assign init_busy = init_busy_q;

	// one store per bank: the current row's bank does the z-test update, the
	// previous row's bank is read out and cleared back to a hole
	for (genvar g = 0; g < 2; g++) begin : g_bank
		dfw_entry_t    mem_q [MAX_WIDTH];
		dfw_entry_t    rd_s1, wd, fwd_data_q;
		logic [AW-1:0] ra, ra_s1, wa, fwd_addr_q;
		logic          we, fwd_en_q;

		assign ra = (q_attr.bank == 1'(g)) ? q_t : q_x;

		always_comb begin
			we = 1'b0;
			wa = clr_cnt_q;
			wd = ENTRY_HOLE;
			if (init_busy_q) begin
				we = 1'b1;
			end else if (b_adv) begin
				if (attr_s1.bank == 1'(g)) begin
					we = win;
					wa = t_s1;
					wd = '{hole: 1'b0, depth: attr_s1.depth, red: attr_s1.red,
						green: attr_s1.green, blue: attr_s1.blue};
				end else begin
					we = 1'b1;
					wa = x_s1;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (we) begin
				mem_q[wa] <= wd;
			end
			if (issue) begin
				rd_s1      <= mem_q[ra];
				ra_s1      <= ra;
				fwd_addr_q <= wa;
				fwd_data_q <= wd;
			end
		end

		// a write landing on the same edge as the read is missed by the read
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				fwd_en_q <= 1'b0;
			end else if (issue) begin
				fwd_en_q <= we;
			end
		end

		assign rdf[g] = (fwd_en_q && fwd_addr_q == ra_s1) ? fwd_data_q : rd_s1;
	end

	assign cur_e  = attr_s1.bank ? rdf[1] : rdf[0];
	assign prev_e = attr_s1.bank ? rdf[0] : rdf[1];
	assign win    = attr_s1.warp &&
		(cur_e.hole ? attr_s1.lt_max : (attr_s1.depth < cur_e.depth));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_busy_q <= 1'b1;
			clr_cnt_q   <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (init_busy_q) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
				if (clr_cnt_q == AW'(MAX_WIDTH - 1)) begin
					init_busy_q <= 1'b0;
				end
			end
			if (b_free) begin
				vld_s1 <= issue;
			end
			if (b_adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			attr_s1 <= q_attr;
			x_s1    <= q_x;
			t_s1    <= q_t;
		end
		if (b_adv) begin
			red_q   <= prev_e.hole ? 8'd0 : prev_e.red;
			green_q <= prev_e.hole ? 8'd0 : prev_e.green;
			blue_q  <= prev_e.hole ? 8'd0 : prev_e.blue;
			hole_q  <= prev_e.hole;
			last_q  <= attr_s1.last;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_red     = red_q;
	assign out_green   = green_q;
	assign out_blue    = blue_q;
	assign hole        = hole_q;
	assign last_in_row = last_q;

endmodule

[rtl/core/depth_forward_warp_row.sv]
// Streaming forward warp of one view: raster pixels (8-bit depth, RGB) are
// shifted left by (far_depth - depth) * disp_scale * view_offset / 256
// (Q8.8 scale, truncated toward zero) into a z-tested row store, two banks
// alternating per row. Every accepted pixel produces one result: the entry of
// the previous row at the same column, which is cleared as it is read, so
// output runs one row behind input; feed a row of depth-0 pixels to flush the
// last row. Sustained rate is one pixel per clock while out_ready is high,
// set by the single read and write port of each bank store, with one-entry
// write forwarding covering back-to-back hits. Each pixel passes the front
// pipeline, queue, bank read stage and output register. After reset the block
// sweeps both banks to holes with in_ready low; configuration writes are
// taken at any time and must only be issued while the block is idle.
module depth_forward_warp_row
	import dfw_pkg::*;
#(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             depth_value,
	input  logic [7:0]             src_red,
	input  logic [7:0]             src_green,
	input  logic [7:0]             src_blue,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [7:0]             out_red,
	output logic [7:0]             out_green,
	output logic [7:0]             out_blue,
	output logic                   hole,
	output logic                   last_in_row
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int QW = $bits(dfw_attr_t) + 2 * AW;

	dfw_cfg_t      cfg_q;
	logic          init_busy;

	logic          f_valid, f_ready;
	dfw_attr_t     f_attr;
	logic [AW-1:0] f_x, f_t;

	logic          b_valid, b_ready;
	dfw_attr_t     b_attr;
	logic [AW-1:0] b_x, b_t;
	logic [QW-1:0] q_wdata, q_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (dfw_reg_t'(cfg_index))
				REG_VIEW_OFFSET: cfg_q.view_offset <= signed'(cfg_data[4:0]);
				REG_DISP_SCALE:  cfg_q.disp_scale  <= cfg_data;
				REG_FAR_DEPTH:   cfg_q.far_depth   <= cfg_data[7:0];
				REG_IMAGE_WIDTH: cfg_q.image_width <= cfg_data[WIDTH_REG_W-1:0];
			endcase
		end
	end

	dfw_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.hold       (init_busy),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.depth_value(depth_value),
		.src_red    (src_red),
		.src_green  (src_green),
		.src_blue   (src_blue),
		.item_valid (f_valid),
		.item_ready (f_ready),
		.item_attr  (f_attr),
		.item_x     (f_x),
		.item_t     (f_t)
	);

	assign q_wdata = {f_attr, f_x, f_t};
	assign {b_attr, b_x, b_t} = q_rdata;

	dfw_queue #(
		.DW   (QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (f_valid),
		.in_ready (f_ready),
		.in_data  (q_wdata),
		.out_valid(b_valid),
		.out_ready(b_ready),
		.out_data (q_rdata)
	);

	dfw_back #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (b_valid),
		.q_ready    (b_ready),
		.q_attr     (b_attr),
		.q_x        (b_x),
		.q_t        (b_t),
		.init_busy  (init_busy),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_red    (out_red),
		.out_green  (out_green),
		.out_blue   (out_blue),
		.hole       (hole),
		.last_in_row(last_in_row)
	);

	a_no_accept_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		init_busy |-> !(in_valid && in_ready))
		else $error("pixel accepted during row store init sweep");

	a_hole_is_black: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && hole) |-> (out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0))
		else $error("hole result carries colour");

	a_warp_needs_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(f_valid && f_attr.warp) |-> (f_attr.depth != 8'd0))
		else $error("depth-0 pixel marked for warp");

	a_no_issue_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		init_busy |-> !(b_valid && b_ready))
		else $error("row store accessed during init sweep");

endmodule
